// ===== rtl/hkmc_pkg.sv =====
// Shared types, codes and helper functions of the hunt-and-kill maze carver.
package hkmc_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_CARVED    = 2'd0,
        STATUS_FINISHED  = 2'd1,
        STATUS_RESTARTED = 2'd2
    } status_t;

    // Wall sides, also the order in which neighbors are listed.
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    // Item kinds.
    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_STEP    = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_START_COL   = 2'd2;
    localparam logic [1:0] CFG_START_ROW   = 2'd3;

    // Remainder of a 16-bit value by three. Base-4 digits are all congruent
    // to their own value, so the digits are summed and folded twice.
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] s2;
        logic [2:0] s3;
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + 5'(v[2*i +: 2]);
        end
        s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        if (s3 >= 3'd3)
        begin
            s3 = s3 - 3'd3;
        end
        return s3[1:0];
    endfunction

    // Direction of the sel-th set bit of a candidate mask.
    function automatic dir_t pick_dir(input logic [3:0] cand, input logic [1:0] sel);
        logic [1:0] cnt;
        dir_t       d;
        cnt = '0;
        d   = DIR_UP;
        for (int i = 0; i < 4; i++)
        begin
            if (cand[i])
            begin
                if (cnt == sel)
                begin
                    d = dir_t'(2'(i));
                end
                cnt = cnt + 2'd1;
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/hunt_and_kill_maze_carver.sv =====
// Top level of the hunt-and-kill maze carver: sequencer, row window and bitmap RAM.
//
//   channel   direction  handshake            word contents
//   in        sink       in_valid / in_ready  kind, random_value
//   out       source     out_valid/out_ready  status, wall_*, current_*
//   cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// The visited bitmap sits in a RAM of MAX_ROWS rows, each MAX_COLS bits wide.
// A step reads the rows above, at and below the cursor (one RAM read a cycle).
// When a wall is carved from the cursor, the step passes through fetch, wait, kill
// and emit. A dead end starts a hunt that refetches from the top row and then
// slides the window down one row at a time until it finds a cell or has checked
// the last row. A restart writes the start cell; a step on a finished maze just emits.
// Reset and restart clear a valid flip-flop per row instead of the RAM, so no
// clearing pass is needed. A new word is taken once the previous one is in the
// output register; a stalled output holds the next result at its last state.
module hunt_and_kill_maze_carver #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [15:0]         random_value,
    output logic                out_valid,
    input  logic                out_ready,
    output hkmc_pkg::status_t   status,
    output logic [5:0]          wall_col,
    output logic [5:0]          wall_row,
    output hkmc_pkg::dir_t      wall_dir,
    output logic [5:0]          current_col,
    output logic [5:0]          current_row,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_data
);

    import hkmc_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int WW = $clog2(MAX_COLS + 1);
    localparam int HW = $clog2(MAX_ROWS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESTART,
        S_FETCH,
        S_FWAIT,
        S_KILL,
        S_HEVAL,
        S_HPICK,
        S_HWAIT,
        S_EMIT
    } state_t;

    // Control state.
    state_t                state_reg, state_next;
    logic                  hunt_reg, hunt_next;
    logic [1:0]            fetch_cnt_reg, fetch_cnt_next;
    logic [RW-1:0]         scan_row_reg, scan_row_next;
    logic [CW-1:0]         cursor_col_reg, cursor_col_next;
    logic [RW-1:0]         cursor_row_reg, cursor_row_next;
    logic                  finished_reg, finished_next;
    logic [MAX_ROWS-1:0]   rowvalid_reg, rowvalid_next;
    logic                  rd_pending_reg;
    logic                  rd_valid_reg;

    // Result being built for the current word.
    status_t               res_status_reg, res_status_next;
    logic [CW-1:0]         res_col_reg, res_col_next;
    logic [RW-1:0]         res_row_reg, res_row_next;
    dir_t                  res_dir_reg, res_dir_next;

    // Output register.
    logic                  out_valid_reg;
    status_t               status_reg;
    logic [5:0]            wall_col_reg, wall_row_reg, current_col_reg, current_row_reg;
    dir_t                  wall_dir_reg;

    // Configuration registers.
    logic [6:0]            grid_width_reg, grid_height_reg;
    logic [5:0]            start_col_reg, start_row_reg;

    // Row window and chooser values (payload, no reset).
    logic [MAX_COLS-1:0]   up_row_reg, mid_row_reg, dn_row_reg;
    logic [MAX_COLS-1:0]   hits_reg, hits_next;
    logic [1:0]            rnd_lo_reg;
    logic [1:0]            rnd_m3_reg;

    // RAM port signals.
    logic                  mem_wr_en;
    logic [RW-1:0]         mem_wr_addr;
    logic [MAX_COLS-1:0]   mem_wr_data;
    logic                  mem_rd_en;
    logic [RW-1:0]         mem_rd_addr;
    logic [MAX_COLS-1:0]   mem_rd_data;

    // Derived grid values.
    logic [WW-1:0]         eff_w;
    logic [HW-1:0]         eff_h;
    logic [CW-1:0]         sat_col;
    logic [RW-1:0]         sat_row;
    logic [MAX_COLS-1:0]   col_mask;

    // Neighbor evaluation.
    logic [CW-1:0]         ev_col, col_m1, col_p1, hunt_col;
    logic                  want, hunt_any;
    logic                  col_in, row_in;
    logic [3:0]            cand;
    logic [2:0]            cand_n;
    logic [1:0]            sel;
    dir_t                  pick;
    logic                  accept;

    hkmc_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_visited (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign wall_col    = wall_col_reg;
    assign wall_row    = wall_row_reg;
    assign wall_dir    = wall_dir_reg;
    assign current_col = current_col_reg;
    assign current_row = current_row_reg;

    // A grid size of zero counts as one, anything above the maximum as the maximum.
    always_comb
    begin
        if (grid_width_reg == '0)
            eff_w = WW'(1);
        else if (32'(grid_width_reg) > MAX_COLS)
            eff_w = WW'(MAX_COLS);
        else
            eff_w = WW'(grid_width_reg);

        if (grid_height_reg == '0)
            eff_h = HW'(1);
        else if (32'(grid_height_reg) > MAX_ROWS)
            eff_h = HW'(MAX_ROWS);
        else
            eff_h = HW'(grid_height_reg);

        // The start cell saturates to the last column and row of the grid.
        if (32'(start_col_reg) >= 32'(eff_w))
            sat_col = CW'(eff_w - 1'b1);
        else
            sat_col = CW'(start_col_reg);

        if (32'(start_row_reg) >= 32'(eff_h))
            sat_row = RW'(eff_h - 1'b1);
        else
            sat_row = RW'(start_row_reg);

        for (int x = 0; x < MAX_COLS; x++)
        begin
            col_mask[x] = (32'(x) < 32'(eff_w));
        end
    end

    // Hunt candidates on the center row: unvisited cells inside the grid that
    // have at least one visited neighbor inside the grid.
    always_comb
    begin
        hits_next = col_mask & ~mid_row_reg &
                    ( (up_row_reg & {MAX_COLS{scan_row_reg != '0}})
                    | (mid_row_reg << 1)
                    | ((mid_row_reg & col_mask) >> 1)
                    | (dn_row_reg & {MAX_COLS{(({1'b0, scan_row_reg} + 1'b1) < eff_h)}}) );

        hunt_col = '0;
        for (int i = MAX_COLS - 1; i >= 0; i--)
        begin
            if (hits_reg[i])
            begin
                hunt_col = CW'(i);
            end
        end
        hunt_any = |hits_reg;
    end

    // Neighbor list of one cell of the center row. In the kill phase the cell
    // is the cursor and unvisited neighbors count; in the hunt phase it is the
    // found cell and visited neighbors count.
    always_comb
    begin
        want   = (state_reg != S_KILL);
        ev_col = want ? hunt_col : cursor_col_reg;
        col_m1 = ev_col - 1'b1;
        col_p1 = ev_col + 1'b1;
        col_in = (ev_col < eff_w);
        row_in = (scan_row_reg < eff_h);

        cand[DIR_UP]    = col_in && (scan_row_reg != '0) &&
                          (({1'b0, scan_row_reg} - 1'b1) < eff_h) &&
                          (up_row_reg[ev_col] == want);
        cand[DIR_LEFT]  = row_in && (ev_col != '0) &&
                          (({1'b0, ev_col} - 1'b1) < eff_w) &&
                          (mid_row_reg[col_m1] == want);
        cand[DIR_RIGHT] = row_in && (({1'b0, ev_col} + 1'b1) < eff_w) &&
                          (mid_row_reg[col_p1] == want);
        cand[DIR_DOWN]  = col_in && (({1'b0, scan_row_reg} + 1'b1) < eff_h) &&
                          (dn_row_reg[ev_col] == want);

        cand_n = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
        case (cand_n)
            3'd2:    sel = {1'b0, rnd_lo_reg[0]};
            3'd3:    sel = rnd_m3_reg;
            3'd4:    sel = rnd_lo_reg;
            default: sel = 2'd0;
        endcase
        pick = pick_dir(cand, sel);
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        hunt_next       = hunt_reg;
        fetch_cnt_next  = fetch_cnt_reg;
        scan_row_next   = scan_row_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        finished_next   = finished_reg;
        rowvalid_next   = rowvalid_reg;
        res_status_next = res_status_reg;
        res_col_next    = res_col_reg;
        res_row_next    = res_row_reg;
        res_dir_next    = res_dir_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = scan_row_reg;
        mem_wr_data     = mid_row_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = scan_row_reg - 1'b1 + RW'(fetch_cnt_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_col_next = '0;
                    res_row_next = '0;
                    res_dir_next = DIR_UP;
                    if (kind == KIND_RESTART)
                    begin
                        state_next = S_RESTART;
                    end
                    else if (finished_reg)
                    begin
                        res_status_next = STATUS_FINISHED;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        hunt_next      = 1'b0;
                        fetch_cnt_next = '0;
                        scan_row_next  = cursor_row_reg;
                        state_next     = S_FETCH;
                    end
                end
            end

            S_RESTART:
            begin
                rowvalid_next          = '0;
                rowvalid_next[sat_row] = 1'b1;
                mem_wr_en              = 1'b1;
                mem_wr_addr            = sat_row;
                mem_wr_data            = MAX_COLS'(1) << sat_col;
                cursor_col_next        = sat_col;
                cursor_row_next        = sat_row;
                finished_next          = 1'b0;
                res_status_next        = STATUS_RESTARTED;
                state_next             = S_EMIT;
            end

            // Reads rows scan-1, scan and scan+1 into the window.
            S_FETCH:
            begin
                mem_rd_en      = 1'b1;
                fetch_cnt_next = fetch_cnt_reg + 2'd1;
                if (fetch_cnt_reg == 2'd2)
                begin
                    state_next = S_FWAIT;
                end
            end

            S_FWAIT:
            begin
                state_next = hunt_reg ? S_HEVAL : S_KILL;
            end

            S_KILL:
            begin
                if (cand != '0)
                begin
                    res_status_next = STATUS_CARVED;
                    res_col_next    = cursor_col_reg;
                    res_row_next    = cursor_row_reg;
                    res_dir_next    = pick;
                    mem_wr_en       = 1'b1;
                    case (pick)
                        DIR_UP:
                        begin
                            mem_wr_addr     = scan_row_reg - 1'b1;
                            mem_wr_data     = up_row_reg | (MAX_COLS'(1) << cursor_col_reg);
                            cursor_row_next = scan_row_reg - 1'b1;
                        end
                        DIR_LEFT:
                        begin
                            mem_wr_data     = mid_row_reg | (MAX_COLS'(1) << col_m1);
                            cursor_col_next = col_m1;
                        end
                        DIR_RIGHT:
                        begin
                            mem_wr_data     = mid_row_reg | (MAX_COLS'(1) << col_p1);
                            cursor_col_next = col_p1;
                        end
                        default:
                        begin
                            mem_wr_addr     = scan_row_reg + 1'b1;
                            mem_wr_data     = dn_row_reg | (MAX_COLS'(1) << cursor_col_reg);
                            cursor_row_next = scan_row_reg + 1'b1;
                        end
                    endcase
                    rowvalid_next[mem_wr_addr] = 1'b1;
                    state_next                 = S_EMIT;
                end
                else
                begin
                    // Dead end: scan the grid from the top row.
                    hunt_next      = 1'b1;
                    fetch_cnt_next = '0;
                    scan_row_next  = '0;
                    state_next     = S_FETCH;
                end
            end

            S_HEVAL:
            begin
                state_next = S_HPICK;
            end

            S_HPICK:
            begin
                if (hunt_any)
                begin
                    mem_wr_en                   = 1'b1;
                    mem_wr_addr                 = scan_row_reg;
                    mem_wr_data                 = mid_row_reg | (MAX_COLS'(1) << hunt_col);
                    rowvalid_next[scan_row_reg] = 1'b1;
                    cursor_col_next             = hunt_col;
                    cursor_row_next             = scan_row_reg;
                    res_status_next             = STATUS_CARVED;
                    res_col_next                = hunt_col;
                    res_row_next                = scan_row_reg;
                    res_dir_next                = pick;
                    state_next                  = S_EMIT;
                end
                else if (({1'b0, scan_row_reg} + 1'b1) < eff_h)
                begin
                    // Slide the window down one row.
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = scan_row_reg + RW'(2);
                    scan_row_next = scan_row_reg + 1'b1;
                    state_next    = S_HWAIT;
                end
                else
                begin
                    finished_next   = 1'b1;
                    res_status_next = STATUS_FINISHED;
                    state_next      = S_EMIT;
                end
            end

            S_HWAIT:
            begin
                state_next = S_HEVAL;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            hunt_reg        <= 1'b0;
            fetch_cnt_reg   <= '0;
            scan_row_reg    <= '0;
            cursor_col_reg  <= '0;
            cursor_row_reg  <= '0;
            finished_reg    <= 1'b1;
            rowvalid_reg    <= '0;
            rd_pending_reg  <= 1'b0;
            rd_valid_reg    <= 1'b0;
            res_status_reg  <= STATUS_CARVED;
            res_col_reg     <= '0;
            res_row_reg     <= '0;
            res_dir_reg     <= DIR_UP;
            out_valid_reg   <= 1'b0;
            status_reg      <= STATUS_CARVED;
            wall_col_reg    <= '0;
            wall_row_reg    <= '0;
            wall_dir_reg    <= DIR_UP;
            current_col_reg <= '0;
            current_row_reg <= '0;
            grid_width_reg  <= 7'd64;
            grid_height_reg <= 7'd64;
            start_col_reg   <= '0;
            start_row_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            hunt_reg       <= hunt_next;
            fetch_cnt_reg  <= fetch_cnt_next;
            scan_row_reg   <= scan_row_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            finished_reg   <= finished_next;
            rowvalid_reg   <= rowvalid_next;
            res_status_reg <= res_status_next;
            res_col_reg    <= res_col_next;
            res_row_reg    <= res_row_next;
            res_dir_reg    <= res_dir_next;
            rd_pending_reg <= mem_rd_en;
            if (mem_rd_en)
            begin
                rd_valid_reg <= rowvalid_reg[mem_rd_addr];
            end

            if (state_reg == S_EMIT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg   <= 1'b1;
                status_reg      <= res_status_reg;
                wall_col_reg    <= 6'(res_col_reg);
                wall_row_reg    <= 6'(res_row_reg);
                wall_dir_reg    <= res_dir_reg;
                current_col_reg <= 6'(cursor_col_reg);
                current_row_reg <= 6'(cursor_row_reg);
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                    CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                    CFG_START_COL:   start_col_reg   <= cfg_data[5:0];
                    CFG_START_ROW:   start_row_reg   <= cfg_data[5:0];
                    default:         start_row_reg   <= start_row_reg;
                endcase
            end
        end
    end

    // Row window, hunt hits and chooser values. A row whose valid bit was
    // clear when it was read counts as all unvisited.
    always_ff @(posedge clk)
    begin
        if (rd_pending_reg)
        begin
            up_row_reg  <= mid_row_reg;
            mid_row_reg <= dn_row_reg;
            dn_row_reg  <= mem_rd_data & {MAX_COLS{rd_valid_reg}};
        end
        if (state_reg == S_HEVAL)
        begin
            hits_reg <= hits_next;
        end
        if (accept && kind == KIND_STEP)
        begin
            rnd_lo_reg <= random_value[1:0];
            rnd_m3_reg <= mod3_16(random_value);
        end
    end

endmodule

// ===== rtl/hkmc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module hkmc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the hunt-and-kill maze carver with its own carving predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hkmc_pkg::*;

    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    // The run stops offering words once about this many have been accepted.
    localparam int ITEM_TARGET = 390;
    // Length of the long output stall that backs the block up into its input.
    localparam int LONG_HOLD   = 400;
    // Waited out at the end of the run; longer than a full hunt over all 64 rows,
    // so this covers anything the block could still have in flight at the end.
    localparam int END_SETTLE  = 250;

    // One result word as the block should present it.
    typedef struct {
        status_t    status;
        logic [5:0] wall_col;
        logic [5:0] wall_row;
        dir_t       wall_dir;
        logic [5:0] cur_col;
        logic [5:0] cur_row;
    } carve_word_t;

    // Scoreboard: keeps its own copy of the visited bitmap, cursor, finished
    // flag and registers, predicts the result of every accepted input word
    // and checks the result words against those predictions in order.
    class carve_scoreboard;
        bit          visited [MAX_ROWS][MAX_COLS];
        int          cur_col;
        int          cur_row;
        bit          finished;
        logic [6:0]  width_reg;
        logic [6:0]  height_reg;
        logic [5:0]  start_col_reg;
        logic [5:0]  start_row_reg;
        carve_word_t expected_words[$];
        int          errors;

        function new();
            visited       = '{default: 1'b0};
            cur_col       = 0;
            cur_row       = 0;
            finished      = 1'b1;
            width_reg     = 7'd64;
            height_reg    = 7'd64;
            start_col_reg = '0;
            start_row_reg = '0;
            errors        = 0;
        endfunction

        function int eff_width();
            if (width_reg == 0)
            begin
                return 1;
            end
            return (width_reg > MAX_COLS) ? MAX_COLS : int'(width_reg);
        endfunction

        function int eff_height();
            if (height_reg == 0)
            begin
                return 1;
            end
            return (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [6:0] value);
            case (idx)
                CFG_GRID_WIDTH:  width_reg     = value;
                CFG_GRID_HEIGHT: height_reg    = value;
                CFG_START_COL:   start_col_reg = value[5:0];
                CFG_START_ROW:   start_row_reg = value[5:0];
                default: ;
            endcase
        endfunction

        // Neighbors of (c, r) inside the grid whose visited bit equals want,
        // taken in the order up, left, right, down. Returns the chosen side,
        // or -1 when there is none. The cursor itself may lie outside.
        function int find_neighbor(int c, int r, bit want, logic [15:0] rnd);
            int   w;
            int   h;
            int   n;
            dir_t dirs [4];
            w = eff_width();
            h = eff_height();
            n = 0;
            if (c < w && r > 0 && r - 1 < h && visited[r - 1][c] == want)
            begin
                dirs[n] = DIR_UP;
                n++;
            end
            if (r < h && c > 0 && c - 1 < w && visited[r][c - 1] == want)
            begin
                dirs[n] = DIR_LEFT;
                n++;
            end
            if (r < h && c + 1 < w && visited[r][c + 1] == want)
            begin
                dirs[n] = DIR_RIGHT;
                n++;
            end
            if (c < w && r + 1 < h && visited[r + 1][c] == want)
            begin
                dirs[n] = DIR_DOWN;
                n++;
            end
            if (n == 0)
            begin
                return -1;
            end
            return int'(dirs[int'(rnd) % n]);
        endfunction

        function carve_word_t carve_step(logic k, logic [15:0] rnd);
            carve_word_t res;
            int          w;
            int          h;
            int          d;
            int          x;
            int          y;
            bit          found;
            dir_t        side;
            w            = eff_width();
            h            = eff_height();
            res.status   = STATUS_FINISHED;
            res.wall_col = '0;
            res.wall_row = '0;
            res.wall_dir = DIR_UP;
            if (k == KIND_RESTART)
            begin
                visited  = '{default: 1'b0};
                cur_col  = (start_col_reg > w - 1) ? w - 1 : int'(start_col_reg);
                cur_row  = (start_row_reg > h - 1) ? h - 1 : int'(start_row_reg);
                visited[cur_row][cur_col] = 1'b1;
                finished   = 1'b0;
                res.status = STATUS_RESTARTED;
            end
            else if (!finished)
            begin
                // Walk on from the cursor if it still has a fresh neighbor.
                d = find_neighbor(cur_col, cur_row, 1'b0, rnd);
                if (d >= 0)
                begin
                    side         = dir_t'(2'(d));
                    res.status   = STATUS_CARVED;
                    res.wall_col = 6'(cur_col);
                    res.wall_row = 6'(cur_row);
                    res.wall_dir = side;
                    case (side)
                        DIR_UP:    cur_row--;
                        DIR_LEFT:  cur_col--;
                        DIR_RIGHT: cur_col++;
                        default:   cur_row++;
                    endcase
                    visited[cur_row][cur_col] = 1'b1;
                end
                else
                begin
                    // Hunt: first unvisited cell, row-major, next to the maze.
                    found = 1'b0;
                    for (y = 0; y < h && !found; y++)
                    begin
                        for (x = 0; x < w && !found; x++)
                        begin
                            if (!visited[y][x])
                            begin
                                d = find_neighbor(x, y, 1'b1, rnd);
                                if (d >= 0)
                                begin
                                    visited[y][x] = 1'b1;
                                    cur_col       = x;
                                    cur_row       = y;
                                    res.status    = STATUS_CARVED;
                                    res.wall_col  = 6'(x);
                                    res.wall_row  = 6'(y);
                                    res.wall_dir  = dir_t'(2'(d));
                                    found         = 1'b1;
                                end
                            end
                        end
                    end
                    if (!found)
                    begin
                        finished = 1'b1;
                    end
                end
            end
            res.cur_col = 6'(cur_col);
            res.cur_row = 6'(cur_row);
            return res;
        endfunction

        function void note_word(logic k, logic [15:0] rnd);
            carve_word_t predicted;
            predicted = carve_step(k, rnd);
            expected_words.insert(expected_words.size(), predicted);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_word(status_t st, logic [5:0] wc, logic [5:0] wr, dir_t wd,
                                 logic [5:0] cc, logic [5:0] cr);
            carve_word_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: result word with nothing expected, actual status %0d",
                         $time, st);
                return;
            end
            want = expected_words.pop_front();
            compare_field("status", 8'(want.status), 8'(st));
            compare_field("wall_col", 8'(want.wall_col), 8'(wc));
            compare_field("wall_row", 8'(want.wall_row), 8'(wr));
            compare_field("wall_dir", 8'(want.wall_dir), 8'(wd));
            compare_field("current_col", 8'(want.cur_col), 8'(cc));
            compare_field("current_row", 8'(want.cur_row), 8'(cr));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [15:0] random_value;
    logic        out_valid;
    logic        out_ready;
    status_t     status;
    logic [5:0]  wall_col;
    logic [5:0]  wall_row;
    dir_t        wall_dir;
    logic [5:0]  current_col;
    logic [5:0]  current_row;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    carve_scoreboard tracker = new();

    // When set, both sides run without gaps for the current stretch.
    bit calm_mode      = 1'b0;
    // Raised by the stimulus to ask the receiver for one long stall.
    bit long_hold_req  = 1'b0;
    int items_sent     = 0;

    hunt_and_kill_maze_carver #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .wall_col     (wall_col),
        .wall_row     (wall_row),
        .wall_dir     (wall_dir),
        .current_col  (current_col),
        .current_row  (current_row),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int gap_len();
        int roll;
        if (calm_mode)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            return 0;
        end
        if (roll < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Grid size register value: mostly small grids so mazes finish quickly,
    // with the zero, one, maximum and above-maximum cases mixed in.
    function automatic logic [6:0] pick_size();
        logic [6:0] v;
        case ($urandom_range(0, 11))
            0:       v = 7'd0;
            1:       v = 7'd1;
            2:       v = 7'd64;
            3:       v = 7'($urandom_range(65, 127));
            4:       v = 7'($urandom_range(9, 63));
            default: v = 7'($urandom_range(2, 8));
        endcase
        return v;
    endfunction

    // Offer one input word after a random gap and hold it until it is taken.
    // Valid is only dropped when a gap follows, so back-to-back words keep it
    // high across the edge.
    task automatic send_word(input logic k, input logic [15:0] rnd);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        random_value <= rnd;
        do @(posedge clk); while (!in_ready);
        tracker.note_word(k, rnd);
        items_sent++;
    endtask

    // Stop offering and wait until every predicted result has been checked.
    // Every word yields exactly one result, so the block is idle afterwards.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [6:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_reg(idx, value);
    endtask

    // Write all four registers back to back; only called while idle.
    task automatic configure(input logic [6:0] w, input logic [6:0] h,
                             input logic [6:0] sc, input logic [6:0] sr);
        write_cfg(CFG_GRID_WIDTH, w);
        write_cfg(CFG_GRID_HEIGHT, h);
        write_cfg(CFG_START_COL, sc);
        write_cfg(CFG_START_ROW, sr);
        cfg_valid <= 1'b0;
    endtask

    // Every accepted result word goes straight to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_word(status, wall_col, wall_row, wall_dir, current_col, current_row);
        end
    end

    // Receiver: random stalls on the result channel, plus one long hold-off
    // on request that lets the block fill up and push back on its input.
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                stall = gap_len();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Hard limit on the run, well above the slowest legal run.
    initial
    begin
        #10ms;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        int phase;
        int steps;
        int cells;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        kind         <= KIND_RESTART;
        random_value <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_GRID_WIDTH;
        cfg_data     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The block comes out of reset finished, so a step
        // before any restart must report a finished maze at cell (0, 0).
        send_word(KIND_STEP, 16'h0000);

        // Full 64 by 64 grid from the corner, random values at the extremes.
        send_word(KIND_RESTART, 16'hFFFF);
        send_word(KIND_STEP, 16'hFFFF);
        send_word(KIND_STEP, 16'hAAAA);
        send_word(KIND_STEP, 16'h5555);

        // A 3 by 2 grid with the start far outside it: the start saturates
        // to the last column and row. Seven steps carve all five walls,
        // report finished, and then report finished once more.
        wait_drained();
        configure(7'd3, 7'd2, 7'd63, 7'd63);
        send_word(KIND_RESTART, 16'h0000);
        for (int i = 0; i < 7; i++)
        begin
            send_word(KIND_STEP, 16'($urandom));
        end

        // Zero width and height count as a single cell: finished at once.
        wait_drained();
        configure(7'd0, 7'd0, 7'd0, 7'd0);
        send_word(KIND_RESTART, 16'h1234);
        send_word(KIND_STEP, 16'h4321);

        // Sizes above the maximum clamp to it; start in the far corner.
        wait_drained();
        configure(7'd127, 7'd127, 7'd63, 7'd63);
        send_word(KIND_RESTART, 16'h0000);
        send_word(KIND_STEP, 16'h0003);
        send_word(KIND_STEP, 16'h8001);

        // Shrink the grid mid-maze, which can leave the cursor outside it,
        // then keep stepping until the small maze is finished.
        wait_drained();
        configure(7'd4, 7'd4, 7'd1, 7'd2);
        send_word(KIND_RESTART, 16'h0000);
        for (int i = 0; i < 3; i++)
        begin
            send_word(KIND_STEP, 16'($urandom));
        end
        wait_drained();
        configure(7'd2, 7'd2, 7'd0, 7'd0);
        for (int i = 0; i < 4; i++)
        begin
            send_word(KIND_STEP, 16'($urandom));
        end

        // Random part: each phase picks a fresh configuration, usually
        // restarts, and walks the maze far enough to finish small grids.
        // Some phases skip the restart and carry on with a resized grid, and
        // a few stray restarts land in the middle of a walk.
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            wait_drained();
            calm_mode = ($urandom_range(0, 3) == 0);
            configure(pick_size(), pick_size(),
                      7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            if ($urandom_range(0, 7) != 0)
            begin
                send_word(KIND_RESTART, 16'($urandom));
            end
            cells = tracker.eff_width() * tracker.eff_height();
            steps = cells + $urandom_range(0, 2);
            if (steps > 48)
            begin
                steps = $urandom_range(24, 48);
            end
            if (phase == 2)
            begin
                // Long receiver stall while words keep coming.
                long_hold_req = 1'b1;
                if (steps < 12)
                begin
                    steps = 12;
                end
            end
            for (int i = 0; i < steps; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    send_word(KIND_RESTART, 16'($urandom));
                end
                else
                begin
                    send_word(KIND_STEP, 16'($urandom));
                end
            end
            phase++;
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hkmc_pkg.sv
rtl/hkmc_ram.sv
rtl/hunt_and_kill_maze_carver.sv
dv/testbench.sv
